@@ rtl/core/scch_pkg.sv @@
// Shared types, constants and helpers for the shape cell coverage height block.
`timescale 1ns / 1ps
`default_nettype none

package scch_pkg;

  localparam int GRID_X = 256;
  localparam int GRID_Y = 256;
  localparam int IDX_W  = 8;

  localparam int SQ_STEPS = 24;            // one root bit per stage
  localparam int RAD_W    = 2 * SQ_STEPS;  // radicand width
  localparam int REM_W    = SQ_STEPS + 1;

  localparam logic [22:0] CELL_SIZE_RST  = 23'd205;
  localparam logic [22:0] CELL_RECIP_RST = 23'd81920;

  typedef enum logic [1:0] {
    MODE_CYL  = 2'd0,
    MODE_SPH  = 2'd1,
    MODE_CUB  = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_ORIGIN_X   = 2'd0,
    REG_ORIGIN_Y   = 2'd1,
    REG_CELL_SIZE  = 2'd2,
    REG_CELL_RECIP = 2'd3
  } reg_e;

  // Per-item context carried down the pipe
  typedef struct packed {
    mode_e              mode;
    logic [7:0]         cx;
    logic [7:0]         cy;
    logic signed [24:0] ctr_x13;
    logic signed [24:0] ctr_y13;
    logic [23:0]        r13;
    logic signed [23:0] hgt;
    logic               disc_in;
    logic               cub_in;
  } item_t;

  // Square root stage state
  typedef struct packed {
    logic [RAD_W-1:0]    rad;
    logic [REM_W-1:0]    rem;
    logic [SQ_STEPS-1:0] root;
  } sq_t;

  // Q.25 position to clamped cell index; negative positions clamp to zero.
  function automatic logic [IDX_W-1:0] q25_to_idx(input logic signed [51:0] p,
                                                  input logic [IDX_W-1:0] last);
    logic [26:0] whole;
    whole = p[51:25];
    if (p < 0) begin
      return '0;
    end else if (whole > 27'(last)) begin
      return last;
    end else begin
      return p[25+IDX_W-1:25];
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/scch_in_if.sv @@
// Input channel: one cell and one object per beat.
`timescale 1ns / 1ps
`default_nettype none

interface scch_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [7:0]         cell_x;
  logic [7:0]         cell_y;
  logic signed [23:0] center_x;
  logic signed [23:0] center_y;
  logic [22:0]        radius;
  logic [22:0]        obj_length;
  logic [22:0]        obj_width;
  logic signed [23:0] obj_height;
  logic signed [15:0] cos_angle;
  logic signed [15:0] sin_angle;

  modport source (output valid, mode, cell_x, cell_y, center_x, center_y, radius,
                  obj_length, obj_width, obj_height, cos_angle, sin_angle,
                  input ready);
  modport sink (input valid, mode, cell_x, cell_y, center_x, center_y, radius,
                obj_length, obj_width, obj_height, cos_angle, sin_angle,
                output ready);
endinterface

`default_nettype wire

@@ rtl/core/scch_out_if.sv @@
// Output channel: coverage flag and cell height per beat.
`timescale 1ns / 1ps
`default_nettype none

interface scch_out_if;
  logic               valid;
  logic               ready;
  logic               covered;
  logic signed [23:0] cell_height;

  modport source (output valid, covered, cell_height, input ready);
  modport sink (input valid, covered, cell_height, output ready);
endinterface

`default_nettype wire

@@ rtl/core/shape_cell_coverage_height.sv @@
// Top level: pipelined height-map cell coverage test for one object.
// The 24-stage root pipeline (one root bit per stage) sets most of the pipe's depth.
// Throughput: one beat per cycle; the whole pipe freezes while the output beat waits.
// Reset clears all valid bits and loads the config registers with their
//   defaults (origin 0, cell size 205, cell reciprocal 81920).
`timescale 1ns / 1ps
`default_nettype none

module shape_cell_coverage_height
  import scch_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  scch_in_if.sink          in_i,
  scch_out_if.source       out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // ---------------- config registers ----------------
  logic signed [23:0] origin_x_q, origin_y_q;
  logic [22:0]        cell_size_q, cell_recip_q;
  reg_e               reg_sel;

  assign reg_sel = reg_e'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q   <= '0;
      origin_y_q   <= '0;
      cell_size_q  <= CELL_SIZE_RST;
      cell_recip_q <= CELL_RECIP_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_ORIGIN_X:   origin_x_q   <= pwdata[23:0];
        REG_ORIGIN_Y:   origin_y_q   <= pwdata[23:0];
        REG_CELL_SIZE:  cell_size_q  <= pwdata[22:0];
        REG_CELL_RECIP: cell_recip_q <= pwdata[22:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ORIGIN_X:   prdata = {{8{origin_x_q[23]}}, origin_x_q};
      REG_ORIGIN_Y:   prdata = {{8{origin_y_q[23]}}, origin_y_q};
      REG_CELL_SIZE:  prdata = {9'd0, cell_size_q};
      REG_CELL_RECIP: prdata = {9'd0, cell_recip_q};
      default:        prdata = '0;
    endcase
  end

  logic signed [24:0] ox13, oy13;
  assign ox13 = $signed({origin_x_q, 1'b0});
  assign oy13 = $signed({origin_y_q, 1'b0});

  // ---------------- pipeline control ----------------
  logic en;
  logic out_valid_q;
  assign en          = !out_valid_q || out_o.ready;
  assign in_i.ready  = en;

  // ---------------- stage 1: cell center offset, squares ----------------
  item_t              it1_d, it1_q;
  logic               v1_q;
  logic [31:0]        offx, offy;
  logic signed [33:0] dx1_d, dy1_d, dx1_q, dy1_q;
  logic [45:0]        len2_q, wid2_q;
  logic [22:0]        len1_q, wid1_q;
  logic signed [15:0] cs1_q, sn1_q;

  assign offx = 32'({in_i.cell_x, 1'b1}) * 32'(cell_size_q);
  assign offy = 32'({in_i.cell_y, 1'b1}) * 32'(cell_size_q);

  always_comb begin
    it1_d.mode    = mode_e'(in_i.mode);
    it1_d.cx      = in_i.cell_x;
    it1_d.cy      = in_i.cell_y;
    it1_d.ctr_x13 = $signed({in_i.center_x, 1'b0});
    it1_d.ctr_y13 = $signed({in_i.center_y, 1'b0});
    it1_d.r13     = {in_i.radius, 1'b0};
    it1_d.hgt     = in_i.obj_height;
    it1_d.disc_in = 1'b0;
    it1_d.cub_in  = 1'b0;
    dx1_d = 34'(ox13) + $signed({2'b00, offx}) - 34'(it1_d.ctr_x13);
    dy1_d = 34'(oy13) + $signed({2'b00, offy}) - 34'(it1_d.ctr_y13);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it1_q  <= it1_d;
      dx1_q  <= dx1_d;
      dy1_q  <= dy1_d;
      len2_q <= 46'(in_i.obj_length) * 46'(in_i.obj_length);
      wid2_q <= 46'(in_i.obj_width) * 46'(in_i.obj_width);
      len1_q <= in_i.obj_length;
      wid1_q <= in_i.obj_width;
      cs1_q  <= in_i.cos_angle;
      sn1_q  <= in_i.sin_angle;
    end
  end

  // ---------------- stage 2: disc squares, rotation products ----------------
  localparam logic signed [33:0] DISC_SAT = 34'sd67108864;

  item_t              it2_q;
  logic               v2_q;
  logic signed [27:0] ax, ay;
  logic signed [55:0] ax2_f, ay2_f;
  logic [52:0]        ax2_q, ay2_q;
  logic signed [49:0] xa_q, xb_q, ya_q, yb_q;
  logic [46:0]        s2_q;
  logic [47:0]        rr2_q;
  logic [22:0]        len2c_q, wid2c_q;

  always_comb begin
    if (dx1_q > DISC_SAT)       ax = 28'sd67108864;
    else if (dx1_q < -DISC_SAT) ax = -28'sd67108864;
    else                        ax = dx1_q[27:0];
    if (dy1_q > DISC_SAT)       ay = 28'sd67108864;
    else if (dy1_q < -DISC_SAT) ay = -28'sd67108864;
    else                        ay = dy1_q[27:0];
    ax2_f = ax * ax;
    ay2_f = ay * ay;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it2_q   <= it1_q;
      ax2_q   <= ax2_f[52:0];
      ay2_q   <= ay2_f[52:0];
      xa_q    <= dx1_q * cs1_q;
      xb_q    <= dy1_q * sn1_q;
      ya_q    <= dy1_q * cs1_q;
      yb_q    <= dx1_q * sn1_q;
      s2_q    <= 47'(len2_q) + 47'(wid2_q);
      rr2_q   <= 48'(it1_q.r13) * 48'(it1_q.r13);
      len2c_q <= len1_q;
      wid2c_q <= wid1_q;
    end
  end

  // ---------------- stage 3: sums ----------------
  item_t              it3_q;
  logic               v3_q;
  logic [53:0]        d2_q;
  logic signed [50:0] xr_q, yr_q;
  logic [46:0]        s3_q;
  logic [47:0]        rr3_q;
  logic [22:0]        len3_q, wid3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      it3_q  <= it2_q;
      d2_q   <= 54'(ax2_q) + 54'(ay2_q);
      xr_q   <= 51'(xa_q) + 51'(xb_q);
      yr_q   <= 51'(ya_q) - 51'(yb_q);
      s3_q   <= s2_q;
      rr3_q  <= rr2_q;
      len3_q <= len2c_q;
      wid3_q <= wid2c_q;
    end
  end

  // ---------------- stage 4: shape tests, root operand ----------------
  item_t               it4_d;
  sq_t                 sq4_d;
  logic signed [50:0]  lh, wh;
  logic                disc_in;

  always_comb begin
    lh      = $signed({14'd0, len3_q, 14'd0});
    wh      = $signed({14'd0, wid3_q, 14'd0});
    disc_in = d2_q <= 54'(rr3_q);
    it4_d         = it3_q;
    it4_d.disc_in = disc_in;
    it4_d.cub_in  = (xr_q >= -lh) && (xr_q <= lh) && (yr_q >= -wh) && (yr_q <= wh);
    sq4_d.rem     = '0;
    sq4_d.root    = '0;
    if (it3_q.mode == MODE_CUB) begin
      sq4_d.rad = 48'(s3_q);
    end else if (disc_in) begin
      sq4_d.rad = rr3_q - d2_q[47:0];
    end else begin
      sq4_d.rad = '0;
    end
  end

  // ---------------- root pipeline ----------------
  item_t               sit_q [SQ_STEPS+1];
  sq_t                 sq_q  [SQ_STEPS+1];
  sq_t                 sq_nx [SQ_STEPS];
  logic [SQ_STEPS:0]   sv_q;
  logic [REM_W+1:0]    rem_t [SQ_STEPS];
  logic [REM_W+1:0]    trial [SQ_STEPS];
  logic [REM_W+1:0]    diff  [SQ_STEPS];

  always_comb begin
    for (int k = 0; k < SQ_STEPS; k++) begin
      rem_t[k] = {sq_q[k].rem, sq_q[k].rad[RAD_W-1 -: 2]};
      trial[k] = {1'b0, sq_q[k].root, 2'b01};
      diff[k]  = rem_t[k] - trial[k];
      sq_nx[k].rad = {sq_q[k].rad[RAD_W-3:0], 2'b00};
      if (rem_t[k] >= trial[k]) begin
        sq_nx[k].rem  = diff[k][REM_W-1:0];
        sq_nx[k].root = {sq_q[k].root[SQ_STEPS-2:0], 1'b1};
      end else begin
        sq_nx[k].rem  = rem_t[k][REM_W-1:0];
        sq_nx[k].root = {sq_q[k].root[SQ_STEPS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sit_q[0] <= it4_d;
      sq_q[0]  <= sq4_d;
      for (int k = 0; k < SQ_STEPS; k++) begin
        sit_q[k+1] <= sit_q[k];
        sq_q[k+1]  <= sq_nx[k];
      end
    end
  end

  // ---------------- stage B1: box positions, sphere height ----------------
  item_t              itb_q;
  logic               vb_q;
  item_t              itl;
  logic [23:0]        reach, root;
  logic signed [26:0] lox, hix, loy, hiy;
  logic signed [24:0] reach_s;
  logic signed [50:0] pminx_q, pmaxx_q, pminy_q, pmaxy_q;
  logic signed [23:0] sph_h_d, sph_h_q;
  logic [24:0]        hsum;
  logic signed [23:0] recip_s;

  always_comb begin
    itl     = sit_q[SQ_STEPS];
    root    = sq_q[SQ_STEPS].root;
    reach   = (itl.mode == MODE_CUB) ? root : itl.r13;
    reach_s = $signed({1'b0, reach});
    recip_s = $signed({1'b0, cell_recip_q});
    lox = 27'(itl.ctr_x13) - 27'(reach_s) - 27'(ox13);
    hix = 27'(itl.ctr_x13) + 27'(reach_s) - 27'(ox13);
    loy = 27'(itl.ctr_y13) - 27'(reach_s) - 27'(oy13);
    hiy = 27'(itl.ctr_y13) + 27'(reach_s) - 27'(oy13);
    hsum = 25'(itl.r13) + 25'(root);
    sph_h_d = hsum[24] ? 24'sh7FFFFF : $signed({1'b0, hsum[23:1]});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      itb_q   <= itl;
      pminx_q <= lox * recip_s;
      pmaxx_q <= hix * recip_s;
      pminy_q <= loy * recip_s;
      pmaxy_q <= hiy * recip_s;
      sph_h_q <= sph_h_d;
    end
  end

  // ---------------- stage B2: box test, result ----------------
  localparam logic signed [51:0] ONE_Q25 = 52'sd33554432;
  localparam logic [IDX_W-1:0]   LAST_X  = IDX_W'(GRID_X - 1);
  localparam logic [IDX_W-1:0]   LAST_Y  = IDX_W'(GRID_Y - 1);

  logic [IDX_W-1:0]   lo_x, hi_x, lo_y, hi_y;
  logic               in_x, in_y, cov_d, covered_q;
  logic signed [23:0] height_d, height_q;
  mode_e              mode_q;

  always_comb begin
    lo_x = q25_to_idx(52'(pminx_q) - ONE_Q25, LAST_X);
    hi_x = q25_to_idx(52'(pmaxx_q) + ONE_Q25, LAST_X);
    lo_y = q25_to_idx(52'(pminy_q) - ONE_Q25, LAST_Y);
    hi_y = q25_to_idx(52'(pmaxy_q) + ONE_Q25, LAST_Y);
    in_x = (hi_x > lo_x) && (itb_q.cx >= lo_x) && (itb_q.cx <= hi_x);
    in_y = (hi_y > lo_y) && (itb_q.cy >= lo_y) && (itb_q.cy <= hi_y);
    cov_d = 1'b0;
    case (itb_q.mode) inside
      MODE_CYL, MODE_SPH: cov_d = in_x && in_y && itb_q.disc_in;
      MODE_CUB:           cov_d = in_x && in_y && itb_q.cub_in;
      default:            cov_d = 1'b0;
    endcase
    if (!cov_d)                      height_d = '0;
    else if (itb_q.mode == MODE_SPH) height_d = sph_h_q;
    else                             height_d = itb_q.hgt;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      covered_q <= cov_d;
      height_q  <= height_d;
      mode_q    <= itb_q.mode;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      sv_q        <= '0;
      vb_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_i.valid;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      sv_q        <= {sv_q[SQ_STEPS-1:0], v3_q};
      vb_q        <= sv_q[SQ_STEPS];
      out_valid_q <= vb_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.covered     = covered_q;
  assign out_o.cell_height = height_q;

  // ---------------- assertions ----------------
  a_uncov_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !covered_q |-> height_q == '0)
    else $error("uncovered beat with nonzero height");

  a_mode_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && mode_q == MODE_NONE |-> !covered_q)
    else $error("unused mode reported covered");

  a_sph_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && covered_q && mode_q == MODE_SPH |-> !height_q[23])
    else $error("sphere height negative");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && en |=> v1_q)
    else $error("accepted beat lost at pipe entry");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(sv_q) && $stable(vb_q))
    else $error("pipe moved during stall");

endmodule

`default_nettype wire
